// ----- rtl/yuv420_to_rgb_pixel_packer_core_defines.svh -----
// Assertion macros used by the pixel packer top level
`ifndef YUV420_TO_RGB_PIXEL_PACKER_CORE_DEFINES_SVH
`define YUV420_TO_RGB_PIXEL_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define YRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel packer check failed");

// Next-cycle implication, disabled while reset is asserted
`define YRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel packer check failed");

`endif

// ----- rtl/yrp_pkg.sv -----
// Types and constants for the YCbCr 4:2:0 to RGB pixel packer
package yrp_pkg;

  // Output format codes
  localparam logic [3:0] FMT_XRGB32 = 4'd0;
  localparam logic [3:0] FMT_XBGR32 = 4'd1;
  localparam logic [3:0] FMT_RGBX32 = 4'd2;
  localparam logic [3:0] FMT_BGRX32 = 4'd3;
  localparam logic [3:0] FMT_RGB24  = 4'd4;
  localparam logic [3:0] FMT_BGR24  = 4'd5;
  localparam logic [3:0] FMT_RGB565 = 4'd6;
  localparam logic [3:0] FMT_BGR565 = 4'd7;
  localparam logic [3:0] FMT_RGB555 = 4'd8;
  localparam logic [3:0] FMT_BGR555 = 4'd9;

  // Width of the signed matrix sums (largest magnitude is below 2^26)
  localparam int unsigned SumW = 28;

  // BT.601 coefficients, signed fixed point with 16 fraction bits (Q1.16, Q2.16 for COEF_CBU)
  localparam logic signed [17:0] COEF_CY  = 18'sd76310;
  localparam logic signed [17:0] COEF_CRV = 18'sd104635;
  localparam logic signed [18:0] COEF_CBU = 19'sd132278;
  localparam logic signed [17:0] COEF_CGU = 18'sd25690;
  localparam logic signed [17:0] COEF_CGV = 18'sd53294;

  localparam logic signed [SumW-1:0] ROUND_HALF    = 28'sd32768;
  localparam logic signed [9:0]      CHROMA_OFFSET = 10'sd128;
  localparam logic signed [9:0]      LUMA_OFFSET   = 10'sd16;
  localparam logic [7:0]             QUANT_MASK    = 8'hFC;

  // One input transfer: shared chroma pair and a 2x2 luma block
  typedef struct packed {
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
  } yrp_in_t;

  // One output transfer: four packed pixels
  typedef struct packed {
    logic [31:0] pixel_top_left;
    logic [31:0] pixel_top_right;
    logic [31:0] pixel_bottom_left;
    logic [31:0] pixel_bottom_right;
  } yrp_out_t;

  // Chroma contribution shared by the four pixels, rounding term included
  typedef struct packed {
    logic                   quant;
    logic signed [SumW-1:0] r_term;
    logic signed [SumW-1:0] g_term;
    logic signed [SumW-1:0] b_term;
  } yrp_chroma_t;

endpackage

// ----- rtl/yrp_chroma.sv -----
// Shared chroma terms of the BT.601 matrix for one 2x2 block
module yrp_chroma import yrp_pkg::*; (
  input  logic [3:0]  fmt_i,
  input  logic [7:0]  chroma_u_i,
  input  logic [7:0]  chroma_v_i,
  output yrp_chroma_t terms_o
);

  logic                   quant;
  logic [7:0]             cu;
  logic [7:0]             cv;
  logic signed [9:0]      u_off;
  logic signed [9:0]      v_off;
  logic signed [SumW-1:0] rnd;
  logic signed [SumW-1:0] rv_prod;
  logic signed [SumW-1:0] gu_prod;
  logic signed [SumW-1:0] gv_prod;
  logic signed [SumW-1:0] bu_prod;

  // 15/16-bit formats work on 6-bit inputs and skip rounding
  always_comb begin
    quant = fmt_i inside {[FMT_RGB565:FMT_BGR555]};
    cu    = quant ? (chroma_u_i & QUANT_MASK) : chroma_u_i;
    cv    = quant ? (chroma_v_i & QUANT_MASK) : chroma_v_i;
    rnd   = quant ? '0 : ROUND_HALF;
  end

  assign u_off = signed'({2'b00, cu}) - CHROMA_OFFSET;
  assign v_off = signed'({2'b00, cv}) - CHROMA_OFFSET;

  // Coefficient products
  assign rv_prod = SumW'(v_off) * SumW'(COEF_CRV);
  assign gu_prod = SumW'(u_off) * SumW'(COEF_CGU);
  assign gv_prod = SumW'(v_off) * SumW'(COEF_CGV);
  assign bu_prod = SumW'(u_off) * SumW'(COEF_CBU);

  always_comb begin
    terms_o.quant  = quant;
    terms_o.r_term = rv_prod + rnd;
    terms_o.g_term = rnd - gu_prod - gv_prod;
    terms_o.b_term = bu_prod + rnd;
  end

endmodule

// ----- rtl/yrp_pixel.sv -----
// Luma term, saturation and packing for one pixel
module yrp_pixel import yrp_pkg::*; (
  input  logic [3:0]  fmt_i,
  input  logic [7:0]  luma_i,
  input  yrp_chroma_t terms_i,
  output logic [31:0] pixel_o
);

  logic [7:0]             luma;
  logic signed [9:0]      y_off;
  logic signed [SumW-1:0] y_prod;
  logic [7:0]             r;
  logic [7:0]             g;
  logic [7:0]             b;

  // Floor shift by 16, clamp to 0..255
  function automatic logic [7:0] sat_channel(input logic signed [SumW-1:0] sum);
    logic [SumW-17:0] q;
    q = sum[SumW-1:16];
    if (sum[SumW-1]) begin
      return 8'd0;
    end else if (|q[SumW-17:8]) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  assign luma   = terms_i.quant ? (luma_i & QUANT_MASK) : luma_i;
  assign y_off  = signed'({2'b00, luma}) - LUMA_OFFSET;
  assign y_prod = SumW'(y_off) * SumW'(COEF_CY);

  assign r = sat_channel(y_prod + terms_i.r_term);
  assign g = sat_channel(y_prod + terms_i.g_term);
  assign b = sat_channel(y_prod + terms_i.b_term);

  // Channel order and packing
  always_comb begin
    case (fmt_i)
      FMT_XRGB32: pixel_o = {8'h00, r, g, b};
      FMT_XBGR32: pixel_o = {8'h00, b, g, r};
      FMT_RGBX32: pixel_o = {r, g, b, 8'h00};
      FMT_BGRX32: pixel_o = {b, g, r, 8'h00};
      FMT_RGB24:  pixel_o = {8'h00, b, g, r};
      FMT_BGR24:  pixel_o = {8'h00, r, g, b};
      FMT_RGB565: pixel_o = {16'h0000, r[7:3], g[7:2], b[7:3]};
      FMT_BGR565: pixel_o = {16'h0000, b[7:3], g[7:2], r[7:3]};
      FMT_RGB555: pixel_o = {17'h00000, r[7:3], g[7:3], b[7:3]};
      FMT_BGR555: pixel_o = {17'h00000, b[7:3], g[7:3], r[7:3]};
      default:    pixel_o = '0;
    endcase
  end

endmodule

// ----- rtl/yuv420_to_rgb_pixel_packer_core.sv -----
// Top level: YCbCr 4:2:0 2x2 block to four packed RGB pixels
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------
//   in      | input     | in_valid_i / in_stall_o  | in_data_i  (yrp_in_t)
//   out     | output    | out_valid_o / out_stall_i| out_data_o (yrp_out_t)
//   cfg     | input     | cfg_we_i                 | cfg_wdata_i (format code)
//
// One block per clock sustained while the output is not stalled; each block
// passes from input transfer to result through an input register, then the
// multiply/saturate/pack logic into the result register.
// Reset empties both stages and sets the format to xRGB32.
// A stalled output holds its result; the input register still takes a
// transfer while it is empty, so the input stalls only when both are full.
`include "yuv420_to_rgb_pixel_packer_core_defines.svh"

module yuv420_to_rgb_pixel_packer_core import yrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  yrp_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output yrp_out_t   out_data_o
);

  logic [3:0]  format_q;
  logic        s1_valid_q;
  logic        s1_valid_d;
  yrp_in_t     s1_data_q;
  logic        out_valid_q;
  logic        out_valid_d;
  yrp_out_t    out_data_q;
  yrp_out_t    out_data_d;
  logic        s2_ready;
  logic        s1_ready;
  logic        in_xfer;
  logic        s1_move;
  yrp_chroma_t terms;

  // Format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FMT_XRGB32;
    end else if (cfg_we_i) begin
      format_q <= cfg_wdata_i;
    end
  end

  // Pipeline handshake
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_xfer    = in_valid_i && s1_ready;
  assign s1_move    = s1_valid_q && s2_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = s2_ready ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
  end

  // Conversion datapath
  yrp_chroma u_chroma (
    .fmt_i      (format_q),
    .chroma_u_i (s1_data_q.chroma_u),
    .chroma_v_i (s1_data_q.chroma_v),
    .terms_o    (terms)
  );

  yrp_pixel u_pix_tl (
    .fmt_i   (format_q),
    .luma_i  (s1_data_q.luma_top_left),
    .terms_i (terms),
    .pixel_o (out_data_d.pixel_top_left)
  );

  yrp_pixel u_pix_tr (
    .fmt_i   (format_q),
    .luma_i  (s1_data_q.luma_top_right),
    .terms_i (terms),
    .pixel_o (out_data_d.pixel_top_right)
  );

  yrp_pixel u_pix_bl (
    .fmt_i   (format_q),
    .luma_i  (s1_data_q.luma_bottom_left),
    .terms_i (terms),
    .pixel_o (out_data_d.pixel_bottom_left)
  );

  yrp_pixel u_pix_br (
    .fmt_i   (format_q),
    .luma_i  (s1_data_q.luma_bottom_right),
    .terms_i (terms),
    .pixel_o (out_data_d.pixel_bottom_right)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  `YRP_ASSERT_NEXT(a_in_xfer_fills_s1, clk_i, rst_ni, in_xfer, s1_valid_q)
  `YRP_ASSERT_NEXT(a_s1_move_fills_out, clk_i, rst_ni, s1_move, out_valid_q)
  `YRP_ASSERT_IMPL(a_empty_never_stalls, clk_i, rst_ni, !s1_valid_q && !out_valid_q, !in_stall_o)

endmodule
